// File: hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DW = 32;
	localparam int FW = DW - 2;
	localparam int RAD_W = DW + 3;
	localparam int A_W = DW + 1;
	localparam int NUM_W = DW + 1;
	localparam int ROOT_W = DW;
	localparam int SREM_W = DW + 3;
	localparam int X_W = 2 * DW;
	localparam int SQ_STAGES = DW;
	localparam int DEN_W = DW + 1;
	localparam int DREM_W = DW + 2;
	localparam int Q_W = DW - 1;

	localparam logic signed [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef logic signed [DW-1:0] word_t;

	typedef enum logic [1:0] {
		CASE_TRACE,
		CASE_X,
		CASE_Y,
		CASE_Z
	} case_t;

	typedef struct packed {
		case_t                  sel;
		logic                   degen;
		logic [2:0][NUM_W-1:0]  mag;
		logic [2:0]             neg;
	} front_t;

	typedef struct packed {
		case_t               sel;
		logic                degen;
		logic [ROOT_W-1:0]   root;
	} tag_t;

endpackage

// File: hdl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// Valid/ready channels for matrices in and quaternions out.
// ----------------------------------------------------------------------------
interface rmq_in_if;
	logic           valid;
	logic           ready;
	rmq_pkg::word_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		output ready);
endinterface

interface rmq_out_if;
	logic           valid;
	logic           ready;
	rmq_pkg::word_t quat_w, quat_x, quat_y, quat_z;
	logic [1:0]     case_taken;
	logic           degenerate;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, case_taken,
		degenerate, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, case_taken,
		degenerate, output ready);
endinterface

// File: hdl/rotation_matrix_to_quaternion.sv
// Path from accepted matrix to quaternion: front register, square root stages, divider stages, output register.
// Throughput: one matrix per cycle; the square root and the three dividers are
// fully pipelined, one result bit per stage, and stall together on output.
// Reset: arst_n clears every valid bit; the pipeline starts empty.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to quaternion by the four-case trace method, Q2.30 fixed point.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
	input  logic        clk,
	input  logic        arst_n,
	rmq_in_if.sink      matrix,
	rmq_out_if.source   quat
);

	logic                        en;
	logic                        f_valid;
	logic [rmq_pkg::A_W-1:0]     f_a;
	rmq_pkg::front_t             f_side;
	logic                        s_valid;
	logic [rmq_pkg::ROOT_W-1:0]  s_root;
	rmq_pkg::front_t             s_side;
	logic                        d_valid;
	rmq_pkg::tag_t               d_tag;
	logic [2:0][rmq_pkg::Q_W-1:0] d_quo;
	logic [2:0]                  d_ovf, d_neg;
	logic                        valid_q;
	rmq_pkg::word_t              lane [3];
	rmq_pkg::word_t              half;
	rmq_pkg::word_t              w_n, x_n, y_n, z_n;

	assign en = !valid_q || quat.ready;
	assign matrix.ready = en;

	rmq_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(matrix.valid),
		.r00(matrix.r00), .r01(matrix.r01), .r02(matrix.r02),
		.r10(matrix.r10), .r11(matrix.r11), .r12(matrix.r12),
		.r20(matrix.r20), .r21(matrix.r21), .r22(matrix.r22),
		.valid_s1(f_valid), .a_s1(f_a), .side_s1(f_side)
	);

	rmq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_valid), .a(f_a),
		.side_in(f_side), .out_valid(s_valid), .root(s_root), .side_out(s_side)
	);

	rmq_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_valid), .root(s_root),
		.side_in(s_side), .out_valid(d_valid), .tag_out(d_tag), .quo(d_quo),
		.ovf(d_ovf), .neg(d_neg)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (d_ovf[i]) begin
				lane[i] = d_neg[i] ? rmq_pkg::NEG_MIN : rmq_pkg::POS_MAX;
			end else begin
				lane[i] = d_neg[i] ? -$signed({1'b0, d_quo[i]}) : $signed({1'b0, d_quo[i]});
			end
		end
		half = $signed({1'b0, d_tag.root[rmq_pkg::ROOT_W-1:1]});
		w_n = (d_tag.sel == rmq_pkg::CASE_TRACE) ? half : lane[0];
		case (d_tag.sel)
			rmq_pkg::CASE_TRACE: x_n = lane[0];
			rmq_pkg::CASE_X:     x_n = half;
			default:             x_n = lane[1];
		endcase
		case (d_tag.sel)
			rmq_pkg::CASE_Y: y_n = half;
			rmq_pkg::CASE_Z: y_n = lane[2];
			default:         y_n = lane[1];
		endcase
		z_n = (d_tag.sel == rmq_pkg::CASE_Z) ? half : lane[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_w <= d_tag.degen ? '0 : w_n;
			quat.quat_x <= d_tag.degen ? '0 : x_n;
			quat.quat_y <= d_tag.degen ? '0 : y_n;
			quat.quat_z <= d_tag.degen ? '0 : z_n;
			quat.case_taken <= d_tag.sel;
			quat.degenerate <= d_tag.degen;
		end
	end

	assign quat.valid = valid_q;

endmodule

// File: hdl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Case selection, radicand and off-diagonal numerators, one register stage.
// ----------------------------------------------------------------------------
module rmq_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  rmq_pkg::word_t            r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic                      valid_s1,
	output logic [rmq_pkg::A_W-1:0]   a_s1,
	output rmq_pkg::front_t           side_s1
);

	function automatic logic signed [rmq_pkg::RAD_W-1:0] ext_r(rmq_pkg::word_t v);
		return {{(rmq_pkg::RAD_W-rmq_pkg::DW){v[rmq_pkg::DW-1]}}, v};
	endfunction

	function automatic logic signed [rmq_pkg::NUM_W-1:0] ext_n(rmq_pkg::word_t v);
		return {v[rmq_pkg::DW-1], v};
	endfunction

	localparam logic signed [rmq_pkg::RAD_W-1:0] ONE =
		{{(rmq_pkg::RAD_W-rmq_pkg::FW-1){1'b0}}, 1'b1, {rmq_pkg::FW{1'b0}}};

	logic signed [rmq_pkg::RAD_W-1:0] d0, d1, d2, trace, rad;
	logic signed [rmq_pkg::NUM_W-1:0] n_75, n_26, n_31, p_13, p_26, p_57;
	logic signed [rmq_pkg::NUM_W-1:0] n [3];
	rmq_pkg::case_t sel;
	logic degen;

	always_comb begin
		d0 = ext_r(r00);
		d1 = ext_r(r11);
		d2 = ext_r(r22);
		trace = d0 + d1 + d2;
		n_75 = ext_n(r21) - ext_n(r12);
		n_26 = ext_n(r02) - ext_n(r20);
		n_31 = ext_n(r10) - ext_n(r01);
		p_13 = ext_n(r01) + ext_n(r10);
		p_26 = ext_n(r02) + ext_n(r20);
		p_57 = ext_n(r12) + ext_n(r21);
		if (trace > 0) begin
			sel = rmq_pkg::CASE_TRACE;
			rad = ONE + trace;
			n[0] = n_75;
			n[1] = n_26;
			n[2] = n_31;
		end else if (r00 > r11 && r00 > r22) begin
			sel = rmq_pkg::CASE_X;
			rad = ONE + d0 - d1 - d2;
			n[0] = n_75;
			n[1] = p_13;
			n[2] = p_26;
		end else if (r11 > r22) begin
			sel = rmq_pkg::CASE_Y;
			rad = ONE + d1 - d0 - d2;
			n[0] = n_26;
			n[1] = p_13;
			n[2] = p_57;
		end else begin
			sel = rmq_pkg::CASE_Z;
			rad = ONE + d2 - d0 - d1;
			n[0] = n_31;
			n[1] = p_26;
			n[2] = p_57;
		end
		degen = rad[rmq_pkg::RAD_W-1] || (rad == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= degen ? '0 : rad[rmq_pkg::A_W-1:0];
			side_s1.sel <= sel;
			side_s1.degen <= degen;
			for (int i = 0; i < 3; i++) begin
				side_s1.neg[i] <= n[i][rmq_pkg::NUM_W-1];
				side_s1.mag[i] <= n[i][rmq_pkg::NUM_W-1] ? -n[i] : n[i];
			end
		end
	end

endmodule

// File: hdl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rmq_pkg::A_W-1:0]     a,
	input  rmq_pkg::front_t             side_in,
	output logic                        out_valid,
	output logic [rmq_pkg::ROOT_W-1:0]  root,
	output rmq_pkg::front_t             side_out
);

	localparam int N = rmq_pkg::SQ_STAGES;

	logic [N-1:0]                vld_s;
	logic [rmq_pkg::SREM_W-1:0]  rem_s  [N];
	logic [rmq_pkg::ROOT_W-1:0]  root_s [N];
	logic [rmq_pkg::X_W-1:0]     x_s    [N];
	rmq_pkg::front_t             side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                        v_i;
		logic [rmq_pkg::SREM_W-1:0]  rem_i, rem_sh, trial;
		logic [rmq_pkg::ROOT_W-1:0]  root_i;
		logic [rmq_pkg::X_W-1:0]     x_i;
		rmq_pkg::front_t             side_i;

		if (k == 0) begin : g_first
			assign v_i = in_valid;
			assign rem_i = '0;
			assign root_i = '0;
			assign x_i = {1'b0, a, {rmq_pkg::FW{1'b0}}};
			assign side_i = side_in;
		end else begin : g_next
			assign v_i = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign x_i = x_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign rem_sh = {rem_i[rmq_pkg::SREM_W-3:0], x_i[rmq_pkg::X_W-1 -: 2]};
		assign trial = {{(rmq_pkg::SREM_W-rmq_pkg::ROOT_W-2){1'b0}}, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k] <= {x_i[rmq_pkg::X_W-3:0], 2'b00};
				side_s[k] <= side_i;
				if (rem_sh >= trial) begin
					rem_s[k] <= rem_sh - trial;
					root_s[k] <= {root_i[rmq_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_sh;
					root_s[k] <= {root_i[rmq_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

// File: hdl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rmq_pkg::ROOT_W-1:0]  root,
	input  rmq_pkg::front_t             side_in,
	output logic                        out_valid,
	output rmq_pkg::tag_t               tag_out,
	output logic [2:0][rmq_pkg::Q_W-1:0] quo,
	output logic [2:0]                  ovf,
	output logic [2:0]                  neg
);

	localparam int N = rmq_pkg::Q_W;

	logic [N:0]                          vld_s;
	rmq_pkg::tag_t                       tag_s  [N+1];
	logic [rmq_pkg::DEN_W-1:0]           den_s  [N+1];
	logic [2:0][rmq_pkg::DREM_W-1:0]     rem_s  [N+1];
	logic [2:0][rmq_pkg::Q_W-1:0]        q_s    [N+1];
	logic [2:0]                          ovf_s  [N+1];
	logic [2:0]                          neg_s  [N+1];
	logic [2:0]                          lsb_s  [N+1];

	logic [rmq_pkg::DEN_W-1:0] den_in;
	assign den_in = {root, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0].sel <= side_in.sel;
			tag_s[0].degen <= side_in.degen || (root == '0);
			tag_s[0].root <= root;
			den_s[0] <= den_in;
			neg_s[0] <= side_in.neg;
			for (int i = 0; i < 3; i++) begin
				ovf_s[0][i] <= {1'b0, side_in.mag[i]} >= {den_in, 1'b0};
				rem_s[0][i] <= {1'b0, side_in.mag[i] >> 1};
				lsb_s[0][i] <= side_in.mag[i][0];
				q_s[0][i] <= '0;
			end
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [2:0][rmq_pkg::DREM_W-1:0] rem_sh;
		logic [rmq_pkg::DREM_W-1:0]      den_x;

		assign den_x = {1'b0, den_s[j]};

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_sh[i] = {rem_s[j][i][rmq_pkg::DREM_W-2:0],
					(j == 0) ? lsb_s[j][i] : 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[j+1] <= tag_s[j];
				den_s[j+1] <= den_s[j];
				ovf_s[j+1] <= ovf_s[j];
				neg_s[j+1] <= neg_s[j];
				lsb_s[j+1] <= lsb_s[j];
				for (int i = 0; i < 3; i++) begin
					if (rem_sh[i] >= den_x) begin
						rem_s[j+1][i] <= rem_sh[i] - den_x;
						q_s[j+1][i] <= {q_s[j][i][rmq_pkg::Q_W-2:0], 1'b1};
					end else begin
						rem_s[j+1][i] <= rem_sh[i];
						q_s[j+1][i] <= {q_s[j][i][rmq_pkg::Q_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign tag_out = tag_s[N];
	assign quo = q_s[N];
	assign ovf = ovf_s[N];
	assign neg = neg_s[N];

endmodule
